// ----- src/bole_pkg.sv -----
// Shared types and constants for the bounded ordered list engine.
// No dependencies; every other file in src uses it by scoped name.
package bole_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int VALUE_W      = 32;
   localparam int POS_W        = 6;
   localparam int LEN_W        = 7;

   typedef enum logic [2:0] {
      OP_INS_FRONT    = 3'd0,
      OP_APPEND       = 3'd1,
      OP_REMOVE_FIRST = 3'd2,
      OP_REMOVE_ALL   = 3'd3,
      OP_REMOVE_AT    = 3'd4,
      OP_READ_AT      = 3'd5,
      OP_READ_END     = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NOMATCH = 2'd1,
      STAT_RANGE   = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_SHIFT,
      S_PUT,
      S_READ,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  item_value;
      logic        [POS_W-1:0]    position;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  read_value;
      status_type                 status;
      logic        [LEN_W-1:0]    list_length;
   } rsp_type;

endpackage

// ----- src/bole_store.sv -----
// Entry store for the list engine: one write port, one read port, registered read data.
// Depends on bole_pkg for the value width.
module bole_store #(
   parameter int DEPTH = bole_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [bole_pkg::VALUE_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [bole_pkg::VALUE_W-1:0]        rd_data
);

   logic [bole_pkg::VALUE_W-1:0] store_mem [DEPTH];
   logic [bole_pkg::VALUE_W-1:0] rd_data_ff;

   // Write one entry, read one entry each cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bounded_ordered_list_engine.sv -----
// Top level of the bounded ordered list engine: sequencer and datapath round one entry store.
// Depends on bole_pkg and bole_store.
//
//   channel   ports                          direction  handshake
//   request   start, busy, req_payload       in         beat taken when start && !busy
//   response  rsp_valid, rsp_payload         out        one-cycle strobe, cannot be held off
//
// Each request beat gives one result strobe; removals and insert-at-front walk the
// stored entries one per cycle through the single read port and single write port of
// the store, which sets the length of an operation.
// Reset empties the list at once; stored entries are not cleared.
// busy stays high from the accepted beat until the result is strobed.
module bounded_ordered_list_engine #(
   parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bole_pkg::req_type req_payload,
   output logic              rsp_valid,
   output bole_pkg::rsp_type rsp_payload
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = CW + bole_pkg::POS_W;

   bole_pkg::state_type  state_ff, state_in;
   bole_pkg::op_type     op_ff, op_in;
   bole_pkg::status_type status_ff, status_in;
   logic [bole_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [bole_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] wptr_ff, wptr_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic          pend_ff, pend_in;
   logic          hit_ff, hit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   bole_pkg::rsp_type rsp_ff, rsp_in;

   logic                         mem_we;
   logic [AW-1:0]                mem_waddr;
   logic [bole_pkg::VALUE_W-1:0] mem_wdata;
   logic [AW-1:0]                mem_raddr;
   logic [bole_pkg::VALUE_W-1:0] mem_rdata;

   logic          accept;
   logic          is_full;
   logic          req_range;
   logic          issue_fwd;
   logic          issue_bwd;
   logic          is_compact;
   logic          is_read;
   logic          drop;
   logic [XW-1:0] from_end;
   logic [CW-1:0] new_count;

   bole_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Decode the request and the walk conditions
   assign busy       = (state_ff != bole_pkg::S_IDLE);
   assign accept     = start && !busy;
   assign is_full    = (count_ff == CW'(CAPACITY));
   assign req_range  = (XW'(req_payload.position) >= XW'(count_ff));
   assign issue_fwd  = (rptr_ff < count_ff);
   assign issue_bwd  = (rptr_ff != '0);
   assign is_compact = (op_ff == bole_pkg::OP_REMOVE_FIRST) ||
                       (op_ff == bole_pkg::OP_REMOVE_ALL) ||
                       (op_ff == bole_pkg::OP_REMOVE_AT);
   assign is_read    = (op_ff == bole_pkg::OP_READ_AT) || (op_ff == bole_pkg::OP_READ_END);
   assign from_end   = XW'(count_ff) - XW'(pos_ff) - XW'(1);
   assign new_count  = (is_compact && hit_ff) ? wptr_ff : count_ff;

   // Decide whether the entry just read leaves the list
   always_comb begin
      case (op_ff)
         bole_pkg::OP_REMOVE_FIRST: drop = (mem_rdata == val_ff) && !hit_ff;
         bole_pkg::OP_REMOVE_ALL:   drop = (mem_rdata == val_ff);
         bole_pkg::OP_REMOVE_AT:    drop = (XW'(pidx_ff) == XW'(pos_ff));
         default:                   drop = 1'b0;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bole_pkg::S_IDLE: begin
            if (accept) begin
               case (req_payload.op)
                  bole_pkg::OP_INS_FRONT: begin
                     if (is_full) begin
                        state_in = bole_pkg::S_DONE;
                     end else if (count_ff != '0) begin
                        state_in = bole_pkg::S_SHIFT;
                     end else begin
                        state_in = bole_pkg::S_PUT;
                     end
                  end
                  bole_pkg::OP_APPEND:
                     state_in = is_full ? bole_pkg::S_DONE : bole_pkg::S_PUT;
                  bole_pkg::OP_REMOVE_FIRST, bole_pkg::OP_REMOVE_ALL:
                     state_in = (count_ff == '0) ? bole_pkg::S_DONE : bole_pkg::S_WALK;
                  bole_pkg::OP_REMOVE_AT:
                     state_in = req_range ? bole_pkg::S_DONE : bole_pkg::S_WALK;
                  bole_pkg::OP_READ_AT, bole_pkg::OP_READ_END:
                     state_in = req_range ? bole_pkg::S_DONE : bole_pkg::S_READ;
                  default:
                     state_in = bole_pkg::S_DONE;
               endcase
            end
         end
         bole_pkg::S_WALK: begin
            if (!issue_fwd) begin
               state_in = bole_pkg::S_DONE;
            end
         end
         bole_pkg::S_SHIFT: begin
            if (!issue_bwd) begin
               state_in = bole_pkg::S_PUT;
            end
         end
         bole_pkg::S_PUT:  state_in = bole_pkg::S_DONE;
         bole_pkg::S_READ: state_in = bole_pkg::S_DONE;
         bole_pkg::S_DONE: state_in = bole_pkg::S_IDLE;
         default:          state_in = bole_pkg::S_IDLE;
      endcase
   end

   // Datapath and store controls per state
   always_comb begin
      op_in        = op_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      rptr_in      = rptr_ff;
      wptr_in      = wptr_ff;
      pidx_in      = pidx_ff;
      pend_in      = pend_ff;
      hit_in       = hit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = mem_rdata;
      mem_raddr    = '0;
      case (state_ff)
         bole_pkg::S_IDLE: begin
            // Capture the request beat and preset the walk
            if (accept) begin
               op_in   = req_payload.op;
               val_in  = req_payload.item_value;
               pos_in  = req_payload.position;
               wptr_in = '0;
               hit_in  = 1'b0;
               pend_in = 1'b0;
               rptr_in = (req_payload.op == bole_pkg::OP_INS_FRONT) ? count_ff : '0;
               case (req_payload.op)
                  bole_pkg::OP_INS_FRONT, bole_pkg::OP_APPEND:
                     status_in = is_full ? bole_pkg::STAT_FULL : bole_pkg::STAT_OK;
                  bole_pkg::OP_REMOVE_FIRST, bole_pkg::OP_REMOVE_ALL:
                     status_in = bole_pkg::STAT_NOMATCH;
                  bole_pkg::OP_REMOVE_AT, bole_pkg::OP_READ_AT, bole_pkg::OP_READ_END:
                     status_in = req_range ? bole_pkg::STAT_RANGE : bole_pkg::STAT_OK;
                  default:
                     status_in = bole_pkg::STAT_OK;
               endcase
            end
         end
         bole_pkg::S_WALK: begin
            // Read forward one entry a cycle; compact kept entries down to the write pointer
            mem_raddr = AW'(rptr_ff);
            pend_in   = issue_fwd;
            pidx_in   = AW'(rptr_ff);
            if (issue_fwd) begin
               rptr_in = rptr_ff + CW'(1);
            end
            if (pend_ff) begin
               if (drop) begin
                  hit_in = 1'b1;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(wptr_ff);
                  mem_wdata = mem_rdata;
                  wptr_in   = wptr_ff + CW'(1);
               end
            end
         end
         bole_pkg::S_SHIFT: begin
            // Read backward from the tail; move each entry up by one place
            mem_raddr = AW'(rptr_ff - CW'(1));
            pend_in   = issue_bwd;
            pidx_in   = AW'(rptr_ff - CW'(1));
            if (issue_bwd) begin
               rptr_in = rptr_ff - CW'(1);
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pidx_ff + AW'(1);
               mem_wdata = mem_rdata;
            end
         end
         bole_pkg::S_PUT: begin
            // Store the new value at the head or the tail
            mem_we    = 1'b1;
            mem_waddr = (op_ff == bole_pkg::OP_INS_FRONT) ? '0 : AW'(count_ff);
            mem_wdata = val_ff;
            count_in  = count_ff + CW'(1);
         end
         bole_pkg::S_READ: begin
            mem_raddr = (op_ff == bole_pkg::OP_READ_END) ? AW'(from_end) : AW'(pos_ff);
         end
         bole_pkg::S_DONE: begin
            // Settle the length and strobe the result beat
            count_in               = new_count;
            rsp_valid_in           = 1'b1;
            rsp_in.read_value      = (is_read && (status_ff == bole_pkg::STAT_OK)) ?
                                     mem_rdata : '0;
            rsp_in.status          = (is_compact && hit_ff) ? bole_pkg::STAT_OK : status_ff;
            rsp_in.list_length     = bole_pkg::LEN_W'(new_count);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bole_pkg::S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      val_ff    <= val_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      rptr_ff   <= rptr_in;
      wptr_ff   <= wptr_in;
      pidx_ff   <= pidx_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- src/bole_check.sv -----
// Port-level checks for the bounded ordered list engine, bound to the top level.
// Depends on bole_pkg and bounded_ordered_list_engine.
module bole_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input bole_pkg::req_type req_payload,
   input logic              rsp_valid,
   input bole_pkg::rsp_type rsp_payload
);

   // Come out of reset idle and silent
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_valid))
      else $error("busy or result strobe just after reset");

   // An accepted beat holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request beat taken but block not busy");

   // A result comes only as the block falls idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobed outside the end of an operation");

   // Never two result beats back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // A failed operation reads nothing
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status != bole_pkg::STAT_OK)) |->
         (rsp_payload.read_value == '0))
      else $error("non-zero read value with a failing status");

endmodule

bind bounded_ordered_list_engine bole_check u_bole_check (.*);

// ----- bench/bounded_ordered_list_engine_test.sv -----
// Self-checking bench for the bounded ordered list engine: drives list operations,
// predicts every result from a queue image of the list and checks each strobed beat.
// Depends on bole_pkg and bounded_ordered_list_engine.
module bounded_ordered_list_engine_test;

   localparam int LIST_CAP    = bole_pkg::CAPACITY_DEF;
   localparam int DRAIN_WAIT  = LIST_CAP + 8;
   localparam int STALL_LIMIT = 1000;
   localparam int REPORT_MAX  = 10;
   localparam logic signed [bole_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [bole_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   logic              clock;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   bole_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   bole_pkg::rsp_type rsp_payload;

   // expected list contents, front at index 0
   logic signed [bole_pkg::VALUE_W-1:0] list_image[$];
   bole_pkg::rsp_type awaited_results[$];
   int      mismatch_count = 0;
   int      idle_pct = 14;
   int      stall_cycles = 0;

   bounded_ordered_list_engine #(.CAPACITY(LIST_CAP)) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one operation to the list image and return the result it must give
   function automatic bole_pkg::rsp_type apply_list_op(input bole_pkg::req_type item);
      bole_pkg::rsp_type outcome;
      int      hit;
      int      pos;
      logic signed [bole_pkg::VALUE_W-1:0] kept[$];
      outcome = '0;
      outcome.status = bole_pkg::STAT_OK;
      pos = int'(item.position);
      hit = -1;
      case (item.op)
         bole_pkg::OP_INS_FRONT, bole_pkg::OP_APPEND: begin
            if (list_image.size() >= LIST_CAP)
               outcome.status = bole_pkg::STAT_FULL;
            else if (item.op == bole_pkg::OP_INS_FRONT)
               list_image.push_front(item.item_value);
            else
               list_image.push_back(item.item_value);
         end
         bole_pkg::OP_REMOVE_FIRST: begin
            foreach (list_image[k])
               if (hit < 0 && list_image[k] == item.item_value)
                  hit = k;
            if (hit < 0)
               outcome.status = bole_pkg::STAT_NOMATCH;
            else
               list_image.delete(hit);
         end
         bole_pkg::OP_REMOVE_ALL: begin
            foreach (list_image[k])
               if (list_image[k] != item.item_value)
                  kept.push_back(list_image[k]);
            if (kept.size() == list_image.size())
               outcome.status = bole_pkg::STAT_NOMATCH;
            list_image = kept;
         end
         bole_pkg::OP_REMOVE_AT, bole_pkg::OP_READ_AT, bole_pkg::OP_READ_END: begin
            if (pos >= list_image.size())
               outcome.status = bole_pkg::STAT_RANGE;
            else if (item.op == bole_pkg::OP_REMOVE_AT)
               list_image.delete(pos);
            else if (item.op == bole_pkg::OP_READ_AT)
               outcome.read_value = list_image[pos];
            else
               outcome.read_value = list_image[list_image.size() - 1 - pos];
         end
         default: begin
         end
      endcase
      outcome.list_length = bole_pkg::LEN_W'(list_image.size());
      return outcome;
   endfunction

   // Offer one beat after a random idle gap and hold it until taken
   task automatic send_op(input bole_pkg::req_type item);
      int gap;
      gap = 0;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < 12)
         gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      awaited_results.push_back(apply_list_op(item));
   endtask

   task automatic send_fields(input bole_pkg::op_type op,
                              input logic signed [bole_pkg::VALUE_W-1:0] value,
                              input logic [bole_pkg::POS_W-1:0] pos);
      bole_pkg::req_type item;
      item.op = op;
      item.item_value = value;
      item.position = pos;
      send_op(item);
   endtask

   task automatic note_mismatch(input string what, input bole_pkg::rsp_type want,
                                input bole_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%0s: expected value %0d status %0d length %0d, %0s %0d status %0d length %0d",
                  what, want.read_value, want.status, want.list_length,
                  "got value", got.read_value, got.status, got.list_length);
   endtask

   // Check each strobed result against the oldest expectation
   always @(posedge clock) begin
      bole_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            note_mismatch("unexpected result", '0, rsp_payload);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_payload.read_value !== want.read_value ||
                rsp_payload.status !== want.status ||
                rsp_payload.list_length !== want.list_length)
               note_mismatch("result mismatch", want, rsp_payload);
         end
      end
   end

   // End the run when neither channel moves for too long
   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || rsp_valid || (start && !busy))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic signed [bole_pkg::VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40 && list_image.size() != 0)
         return list_image[$urandom_range(list_image.size() - 1)];
      if (r < 70) begin
         case ($urandom_range(4))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return 0;
            3: return -1;
            default: return 7;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [bole_pkg::POS_W-1:0] pick_position();
      int top;
      top = (list_image.size() < LIST_CAP) ? list_image.size() : LIST_CAP - 1;
      if ($urandom_range(99) < 70)
         return bole_pkg::POS_W'($urandom_range(top));
      return bole_pkg::POS_W'($urandom_range(LIST_CAP - 1));
   endfunction

   // Weight operations towards filling or draining the list
   function automatic bole_pkg::op_type pick_op(input bit grow);
      int unsigned r;
      r = $urandom_range(99);
      if (grow) begin
         if (r < 30) return bole_pkg::OP_INS_FRONT;
         if (r < 60) return bole_pkg::OP_APPEND;
         if (r < 68) return bole_pkg::OP_REMOVE_FIRST;
         if (r < 71) return bole_pkg::OP_REMOVE_ALL;
         if (r < 78) return bole_pkg::OP_REMOVE_AT;
         if (r < 89) return bole_pkg::OP_READ_AT;
         return bole_pkg::OP_READ_END;
      end
      if (r < 8)  return bole_pkg::OP_INS_FRONT;
      if (r < 16) return bole_pkg::OP_APPEND;
      if (r < 40) return bole_pkg::OP_REMOVE_FIRST;
      if (r < 50) return bole_pkg::OP_REMOVE_ALL;
      if (r < 70) return bole_pkg::OP_REMOVE_AT;
      if (r < 85) return bole_pkg::OP_READ_AT;
      return bole_pkg::OP_READ_END;
   endfunction

   // Every remove and read on an empty list
   task automatic test_empty_list();
      send_fields(bole_pkg::OP_READ_AT, $urandom, 0);
      send_fields(bole_pkg::OP_READ_END, $urandom, 0);
      send_fields(bole_pkg::OP_REMOVE_AT, $urandom, 0);
      send_fields(bole_pkg::OP_REMOVE_FIRST, 0, 0);
      send_fields(bole_pkg::OP_REMOVE_ALL, 0, 0);
   endtask

   // Extreme values at both ends, reads at the boundary and past it
   task automatic test_value_extremes();
      send_fields(bole_pkg::OP_INS_FRONT, VAL_MIN, 0);
      send_fields(bole_pkg::OP_APPEND, VAL_MAX, 63);
      send_fields(bole_pkg::OP_INS_FRONT, 0, 0);
      send_fields(bole_pkg::OP_APPEND, -1, 0);
      send_fields(bole_pkg::OP_READ_AT, $urandom, 0);
      send_fields(bole_pkg::OP_READ_END, $urandom, 0);
      send_fields(bole_pkg::OP_READ_AT, $urandom, 3);
      send_fields(bole_pkg::OP_READ_END, $urandom, 4);
      send_fields(bole_pkg::OP_READ_AT, $urandom, 63);
   endtask

   // Match and no match, removal at the final index, remove-all emptying the list
   task automatic test_removal_cases();
      send_fields(bole_pkg::OP_REMOVE_FIRST, VAL_MAX, 0);
      send_fields(bole_pkg::OP_REMOVE_FIRST, 12345, 0);
      send_fields(bole_pkg::OP_REMOVE_AT, $urandom, 2);
      send_fields(bole_pkg::OP_REMOVE_AT, $urandom, 0);
      send_fields(bole_pkg::OP_APPEND, VAL_MIN, 0);
      send_fields(bole_pkg::OP_INS_FRONT, VAL_MIN, 0);
      send_fields(bole_pkg::OP_REMOVE_ALL, VAL_MIN, 0);
   endtask

   // Fill to capacity, then hit the full list and the last index
   task automatic test_fill_to_capacity();
      while (list_image.size() < LIST_CAP)
         send_fields($urandom_range(1) ? bole_pkg::OP_APPEND : bole_pkg::OP_INS_FRONT,
                     $urandom, bole_pkg::POS_W'($urandom));
      send_fields(bole_pkg::OP_APPEND, $urandom, 0);
      send_fields(bole_pkg::OP_INS_FRONT, $urandom, 0);
      send_fields(bole_pkg::OP_READ_AT, $urandom, 63);
      send_fields(bole_pkg::OP_READ_END, $urandom, 63);
      send_fields(bole_pkg::OP_REMOVE_AT, $urandom, 63);
      send_fields(bole_pkg::OP_INS_FRONT, VAL_MAX, 0);
      send_fields(bole_pkg::OP_REMOVE_FIRST, VAL_MAX, 0);
   endtask

   // Random traffic swinging the length between empty and full
   task automatic test_random_traffic(input int count);
      bit                grow;
      bole_pkg::req_type item;
      grow = 1'b1;
      repeat (count) begin
         if (grow && list_image.size() >= LIST_CAP && $urandom_range(3) == 0)
            grow = 1'b0;
         else if (!grow && list_image.size() == 0 && $urandom_range(1) == 0)
            grow = 1'b1;
         item.op = pick_op(grow);
         item.item_value = pick_value();
         item.position = pick_position();
         send_op(item);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 14;
      test_empty_list();
      test_value_extremes();
      test_removal_cases();
      test_fill_to_capacity();
      test_random_traffic(160);
      idle_pct = 46;
      test_random_traffic(160);
      idle_pct = 0;
      test_random_traffic(160);
      start <= 1'b0;
      // hold until every result is in, then watch for strays
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sim.f -----
src/bole_pkg.sv
src/bole_store.sv
src/bounded_ordered_list_engine.sv
src/bole_check.sv
bench/bounded_ordered_list_engine_test.sv
